FILE: rtl/pip_pkg.sv
package pip_pkg;

  localparam int COUNT_BITS   = 7;
  localparam int INDEX_BITS   = 6;
  localparam int REL_BITS     = 2;
  localparam int MIN_VERTICES = 3;
  localparam int EVAL_LATENCY = 5;
  localparam int DRAIN_BITS   = 3;

  localparam logic [COUNT_BITS-1:0] COUNT_RESET = COUNT_BITS'(MIN_VERTICES);

  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  localparam logic [REL_BITS-1:0] REL_OUTSIDE  = 2'd0;
  localparam logic [REL_BITS-1:0] REL_BOUNDARY = 2'd1;
  localparam logic [REL_BITS-1:0] REL_INSIDE   = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } pip_state_t;

  typedef struct packed {
    logic shift;
    logic write;
  } pip_cell_ctrl_t;

  typedef struct packed {
    logic clear;
    logic valid;
  } pip_edge_ctrl_t;

  typedef struct packed {
    logic valid;
    logic in_box;
    logic straddle;
    logic rising;
  } pip_edge_info_t;

endpackage

FILE: rtl/pip_in_if.sv
interface pip_in_if
  import pip_pkg::*;
#(
  parameter int COORD_BITS = 32
) ();
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [INDEX_BITS-1:0]        vertex_index;
  logic signed [COORD_BITS-1:0] coord_x;
  logic signed [COORD_BITS-1:0] coord_y;

  modport source (
    output valid, kind, vertex_index, coord_x, coord_y,
    input  ready
  );

  modport sink (
    input  valid, kind, vertex_index, coord_x, coord_y,
    output ready
  );
endinterface

FILE: rtl/pip_out_if.sv
interface pip_out_if
  import pip_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [REL_BITS-1:0] relation;

  modport source (
    output valid, relation,
    input  ready
  );

  modport sink (
    input  valid, relation,
    output ready
  );
endinterface

FILE: rtl/point_in_polygon_classifier.sv
// a query is evaluated as the vertex ring turns one place a cycle
//   past the single edge evaluator; no new item is taken until its result
//   is loaded into the result register
// the result register holds a finished answer while the next item is taken
// reset: synchronous active low, vertex count returns to 3, vertex cells are not cleared
module point_in_polygon_classifier
  import pip_pkg::*;
#(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_BITS   = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  pip_in_if.sink                in_ch,
  pip_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [COUNT_BITS-1:0] cfg_wdata
);

  localparam int KW = $clog2(MAX_VERTICES);
  localparam int NW = $clog2(MAX_VERTICES + 1);
  localparam int CW = (NW > COUNT_BITS) ? NW : COUNT_BITS;

  pip_state_t state_r, state_nxt;

  logic [KW-1:0]                step_r;
  logic [DRAIN_BITS-1:0]        drain_r;
  logic [NW-1:0]                n_r;
  logic [NW-1:0]                n_nxt;
  logic [COUNT_BITS-1:0]        count_r;
  logic signed [COORD_BITS-1:0] px_r, py_r, v0x_r, v0y_r;
  logic                         out_valid_r;
  logic [REL_BITS-1:0]          relation_r;

  logic                         in_ready;
  logic                         in_acc;
  logic                         query_start;
  logic                         vtx_wr;
  logic                         shift_en;
  logic                         load_out;
  logic                         last_edge;
  logic [CW-1:0]                count_ext;
  logic [REL_BITS-1:0]          eval_rel;
  pip_edge_ctrl_t               edge_ctrl;
  logic signed [COORD_BITS-1:0] edge_bx, edge_by;

  logic signed [COORD_BITS-1:0] cell_x [MAX_VERTICES];
  logic signed [COORD_BITS-1:0] cell_y [MAX_VERTICES];

  assign in_acc      = in_ch.valid && in_ready;
  assign query_start = in_acc && (in_ch.kind == KIND_QUERY);
  assign vtx_wr      = in_acc && (in_ch.kind == KIND_VERTEX);

  // vertex ring
  for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_cell
    pip_cell_ctrl_t cell_ctrl;

    assign cell_ctrl.shift = shift_en;
    assign cell_ctrl.write = vtx_wr && (int'(in_ch.vertex_index) == i);

    pip_vertex_cell #(
      .COORD_BITS(COORD_BITS)
    ) u_cell (
      .clk  (clk),
      .ctrl (cell_ctrl),
      .wr_x (in_ch.coord_x),
      .wr_y (in_ch.coord_y),
      .nb_x (cell_x[(i + 1) % MAX_VERTICES]),
      .nb_y (cell_y[(i + 1) % MAX_VERTICES]),
      .x    (cell_x[i]),
      .y    (cell_y[i])
    );
  end

  // clamp of the vertex count
  assign count_ext = CW'(count_r);

  always_comb begin
    priority if (count_ext < CW'(MIN_VERTICES)) begin
      n_nxt = NW'(MIN_VERTICES);
    end else if (count_ext > CW'(MAX_VERTICES)) begin
      n_nxt = NW'(MAX_VERTICES);
    end else begin
      n_nxt = NW'(count_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= COUNT_RESET;
    end else if (cfg_we) begin
      count_r <= cfg_wdata;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (query_start) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (step_r == KW'(MAX_VERTICES - 1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain_r == DRAIN_BITS'(EVAL_LATENCY - 1)) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    shift_en = 1'b0;
    load_out = 1'b0;
    unique case (state_r)
      ST_IDLE:   in_ready = 1'b1;
      ST_RUN:    shift_en = 1'b1;
      ST_DRAIN:  ;
      ST_FINISH: load_out = !out_valid_r || out_ch.ready;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      drain_r <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= shift_en ? step_r + KW'(1) : '0;
      drain_r <= (state_r == ST_DRAIN) ? drain_r + DRAIN_BITS'(1) : '0;
    end
  end

  // query capture
  always_ff @(posedge clk) begin
    if (query_start) begin
      px_r  <= in_ch.coord_x;
      py_r  <= in_ch.coord_y;
      v0x_r <= cell_x[0];
      v0y_r <= cell_y[0];
      n_r   <= n_nxt;
    end
  end

  // closing edge wraps to vertex 0
  assign last_edge = NW'(step_r) == n_r - NW'(1);
  assign edge_bx   = last_edge ? v0x_r : cell_x[1 % MAX_VERTICES];
  assign edge_by   = last_edge ? v0y_r : cell_y[1 % MAX_VERTICES];

  assign edge_ctrl.clear = query_start;
  assign edge_ctrl.valid = shift_en && (NW'(step_r) < n_r);

  pip_edge_eval #(
    .COORD_BITS(COORD_BITS)
  ) u_eval (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (edge_ctrl),
    .ax       (cell_x[0]),
    .ay       (cell_y[0]),
    .bx       (edge_bx),
    .by       (edge_by),
    .px       (px_r),
    .py       (py_r),
    .relation (eval_rel)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      relation_r <= eval_rel;
    end
  end

  assign in_ch.ready     = in_ready;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.relation = relation_r;

endmodule

FILE: rtl/pip_vertex_cell.sv
module pip_vertex_cell
  import pip_pkg::*;
#(
  parameter int COORD_BITS = 32
) (
  input  logic                         clk,
  input  pip_cell_ctrl_t               ctrl,
  input  logic signed [COORD_BITS-1:0] wr_x,
  input  logic signed [COORD_BITS-1:0] wr_y,
  input  logic signed [COORD_BITS-1:0] nb_x,
  input  logic signed [COORD_BITS-1:0] nb_y,
  output logic signed [COORD_BITS-1:0] x,
  output logic signed [COORD_BITS-1:0] y
);

  logic signed [COORD_BITS-1:0] x_r;
  logic signed [COORD_BITS-1:0] y_r;

  always_ff @(posedge clk) begin
    if (ctrl.write) begin
      x_r <= wr_x;
      y_r <= wr_y;
    end else if (ctrl.shift) begin
      x_r <= nb_x;
      y_r <= nb_y;
    end
  end

  assign x = x_r;
  assign y = y_r;

endmodule

FILE: rtl/pip_edge_eval.sv
module pip_edge_eval
  import pip_pkg::*;
#(
  parameter int COORD_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pip_edge_ctrl_t               ctrl,
  input  logic signed [COORD_BITS-1:0] ax,
  input  logic signed [COORD_BITS-1:0] ay,
  input  logic signed [COORD_BITS-1:0] bx,
  input  logic signed [COORD_BITS-1:0] by,
  input  logic signed [COORD_BITS-1:0] px,
  input  logic signed [COORD_BITS-1:0] py,
  output logic [REL_BITS-1:0]          relation
);

  localparam int D  = COORD_BITS + 1;
  localparam int H  = (D + 1) / 2;
  localparam int HW = D - H;
  localparam int PW = 2 * D;

  pip_edge_info_t info_r [4];
  pip_edge_info_t info_nxt;

  logic signed [D-1:0]      op_a_r [2];
  logic signed [D-1:0]      op_b_r [2];
  logic signed [2*HW-1:0]   pp_hh_r [2];
  logic signed [D:0]        pp_hl_r [2];
  logic signed [D:0]        pp_lh_r [2];
  logic [2*H-1:0]           pp_ll_r [2];
  logic signed [PW-1:0]     prod_r [2];
  logic signed [PW-1:0]     prod_nxt [2];
  logic signed [PW:0]       diff;
  logic                     neg_r;
  logic                     zero_r;
  logic                     boundary_r;
  logic                     parity_r;
  logic                     toggle;

  // edge side information
  always_comb begin
    info_nxt.valid    = ctrl.valid;
    info_nxt.in_box   = (px >= ax || px >= bx) && (px <= ax || px <= bx) &&
                        (py >= ay || py >= by) && (py <= ay || py <= by);
    info_nxt.straddle = (ay > py) != (by > py);
    info_nxt.rising   = by > ay;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < 4; s++) begin
        info_r[s] <= '0;
      end
    end else begin
      info_r[0] <= info_nxt;
      for (int s = 1; s < 4; s++) begin
        info_r[s] <= info_r[s-1];
      end
    end
  end

  // differences
  always_ff @(posedge clk) begin
    op_a_r[0] <= D'(bx) - D'(ax);
    op_b_r[0] <= D'(py) - D'(ay);
    op_a_r[1] <= D'(by) - D'(ay);
    op_b_r[1] <= D'(px) - D'(ax);
  end

  // partial products
  always_ff @(posedge clk) begin
    for (int k = 0; k < 2; k++) begin
      pp_hh_r[k] <= (2*HW)'($signed(op_a_r[k][D-1:H])) *
                    (2*HW)'($signed(op_b_r[k][D-1:H]));
      pp_hl_r[k] <= (D+1)'($signed(op_a_r[k][D-1:H])) *
                    (D+1)'($signed({1'b0, op_b_r[k][H-1:0]}));
      pp_lh_r[k] <= (D+1)'($signed({1'b0, op_a_r[k][H-1:0]})) *
                    (D+1)'($signed(op_b_r[k][D-1:H]));
      pp_ll_r[k] <= (2*H)'(op_a_r[k][H-1:0]) * (2*H)'(op_b_r[k][H-1:0]);
    end
  end

  // recombine
  always_comb begin
    logic signed [D+1:0] mid;
    for (int k = 0; k < 2; k++) begin
      mid         = (D+2)'(pp_hl_r[k]) + (D+2)'(pp_lh_r[k]);
      prod_nxt[k] = (PW'(pp_hh_r[k]) <<< (2 * H)) + (PW'(mid) <<< H) + PW'(pp_ll_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 2; k++) begin
      prod_r[k] <= prod_nxt[k];
    end
  end

  // cross product sign
  assign diff = (PW+1)'(prod_r[0]) - (PW+1)'(prod_r[1]);

  always_ff @(posedge clk) begin
    neg_r  <= diff[PW];
    zero_r <= (diff == '0);
  end

  assign toggle = info_r[3].straddle && (info_r[3].rising ? (!neg_r && !zero_r) : neg_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      boundary_r <= 1'b0;
      parity_r   <= 1'b0;
    end else if (ctrl.clear) begin
      boundary_r <= 1'b0;
      parity_r   <= 1'b0;
    end else if (info_r[3].valid) begin
      if (zero_r && info_r[3].in_box) begin
        boundary_r <= 1'b1;
      end
      if (toggle) begin
        parity_r <= !parity_r;
      end
    end
  end

  always_comb begin
    if (boundary_r) begin
      relation = REL_BOUNDARY;
    end else if (parity_r) begin
      relation = REL_INSIDE;
    end else begin
      relation = REL_OUTSIDE;
    end
  end

endmodule

FILE: tb/point_in_polygon_classifier_test.sv
module point_in_polygon_classifier_test;
  import pip_pkg::*;

  localparam int MAX_VERTS     = 64;
  localparam int COORD_W       = 32;
  localparam int SETTLE_CYCLES = MAX_VERTS + 16;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int ITEM_TARGET   = 1950;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [71:0]        wide_t;

  localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [COUNT_BITS-1:0] cfg_wdata;

  pip_in_if #(.COORD_BITS(COORD_W)) in_ch ();
  pip_out_if out_ch ();

  point_in_polygon_classifier #(
    .MAX_VERTICES(MAX_VERTS),
    .COORD_BITS  (COORD_W)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // shadow of the polygon and the vertex count
  coord_t                poly_x [MAX_VERTS];
  coord_t                poly_y [MAX_VERTS];
  logic [COUNT_BITS-1:0] count_reg;
  logic [REL_BITS-1:0]   pending_relations [$];

  int send_gap;
  int recv_gap;
  int items_sent;
  int queries_sent;
  int results_seen = 0;
  int fail_count = 0;
  int cycle_count = 0;
  int relation_tally [3];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready = (recv_gap == 0) || ($urandom_range(0, 99) >= recv_gap);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
      $display("point_in_polygon_classifier: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin : result_check
    logic [REL_BITS-1:0] want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending_relations.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected transaction, expected none actual relation %0d",
                 $time, out_ch.relation);
      end else begin
        want = pending_relations.pop_front();
        if (out_ch.relation !== want) begin
          fail_count++;
          $display("%0t: relation expected %0d actual %0d", $time, want, out_ch.relation);
        end
      end
    end
  end

  function automatic int used_vertices();
    if (count_reg < MIN_VERTICES) return MIN_VERTICES;
    if (count_reg > MAX_VERTS) return MAX_VERTS;
    return int'(count_reg);
  endfunction

  // crossing-number test with exact boundary detection
  function automatic logic [REL_BITS-1:0] classify_point(coord_t px, coord_t py);
    int    n;
    int    j;
    logic  odd;
    wide_t ax, ay, bx, by, qx, qy, cp;
    n      = used_vertices();
    odd    = 1'b0;
    qx     = wide_t'(px);
    qy     = wide_t'(py);
    for (int i = 0; i < n; i++) begin
      j     = (i + 1 == n) ? 0 : i + 1;
      ax    = wide_t'(poly_x[i]);
      ay    = wide_t'(poly_y[i]);
      bx    = wide_t'(poly_x[j]);
      by    = wide_t'(poly_y[j]);
      cp    = (bx - ax) * (qy - ay) - (by - ay) * (qx - ax);
      if (cp == 0 && qx >= (ax < bx ? ax : bx) && qx <= (ax < bx ? bx : ax) &&
          qy >= (ay < by ? ay : by) && qy <= (ay < by ? by : ay)) begin
        return REL_BOUNDARY;
      end
      if ((ay > qy) != (by > qy)) begin
        if ((by > ay) ? (cp > 0) : (cp < 0)) odd = !odd;
      end
    end
    return odd ? REL_INSIDE : REL_OUTSIDE;
  endfunction

  task automatic send_item(input logic kind, input logic [INDEX_BITS-1:0] idx,
                           input coord_t x, input coord_t y);
    logic [REL_BITS-1:0] rel;
    @(negedge clk);
    while (send_gap != 0 && $urandom_range(0, 99) < send_gap) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid        = 1'b1;
    in_ch.kind         = kind;
    in_ch.vertex_index = idx;
    in_ch.coord_x      = x;
    in_ch.coord_y      = y;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
    if (kind == KIND_VERTEX) begin
      poly_x[idx] = x;
      poly_y[idx] = y;
    end else begin
      rel = classify_point(x, y);
      pending_relations.push_back(rel);
      relation_tally[rel]++;
      queries_sent++;
    end
  endtask

  task automatic wait_all_answered();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_relations.size() != 0) @(posedge clk);
  endtask

  task automatic set_vertex_count(input logic [COUNT_BITS-1:0] value);
    wait_all_answered();
    // a vertex write may still be in flight
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
    count_reg = value;
  endtask

  // x-monotone simple polygon: lower chain left to right, upper chain back
  task automatic write_monotone(input int n, input int s, input coord_t ox, input coord_t oy);
    int nb;
    int k;
    nb = (n + 1) / 2;
    for (int i = 0; i < n; i++) begin
      if (i < nb) begin
        send_item(KIND_VERTEX, INDEX_BITS'(i), ox + coord_t'(s * 2 * i),
                  oy - coord_t'(s * int'($urandom_range(0, 6))));
      end else begin
        k = i - nb;
        send_item(KIND_VERTEX, INDEX_BITS'(i), ox + coord_t'(s * (2 * (n - nb - 1 - k) + 1)),
                  oy + coord_t'(s * int'($urandom_range(0, 6))));
      end
    end
  endtask

  task automatic send_shaped_query(input int n, input int s);
    int     e;
    int     j;
    int     pick;
    coord_t qx;
    coord_t qy;
    e    = $urandom_range(0, n - 1);
    j    = (e + 1 == n) ? 0 : e + 1;
    pick = $urandom_range(0, 9);
    if (pick < 2) begin
      qx = poly_x[e];
      qy = poly_y[e];
    end else if (pick < 4) begin
      qx = coord_t'((longint'(poly_x[e]) + longint'(poly_x[j])) >>> 1);
      qy = coord_t'((longint'(poly_y[e]) + longint'(poly_y[j])) >>> 1);
    end else if (pick < 9) begin
      qx = poly_x[e] + coord_t'(s * (int'($urandom_range(0, 8)) - 4));
      qy = poly_y[e] + coord_t'(s * (int'($urandom_range(0, 8)) - 4));
    end else begin
      qx = coord_t'($urandom);
      qy = coord_t'($urandom);
    end
    send_item(KIND_QUERY, INDEX_BITS'($urandom), qx, qy);
  endtask

  task automatic test_directed_shapes();
    // extreme triangle
    send_item(KIND_VERTEX, 6'd0, COORD_MIN, COORD_MIN);
    send_item(KIND_VERTEX, 6'd1, COORD_MAX, COORD_MIN);
    send_item(KIND_VERTEX, 6'd2, COORD_MIN, COORD_MAX);
    send_item(KIND_QUERY, 6'd63, COORD_MAX, COORD_MIN);
    send_item(KIND_QUERY, 6'd0, -32'sd1, -32'sd1);
    send_item(KIND_QUERY, 6'd0, COORD_MAX, COORD_MAX);
    send_item(KIND_QUERY, 6'd0, COORD_MIN, 32'sd0);
    send_item(KIND_QUERY, 6'd0, 32'sd0, COORD_MIN);
    // collapsed triangle with a repeated vertex
    send_item(KIND_VERTEX, 6'd0, 32'sd0, 32'sd0);
    send_item(KIND_VERTEX, 6'd1, 32'sd0, 32'sd0);
    send_item(KIND_VERTEX, 6'd2, 32'sd20, 32'sd0);
    send_item(KIND_QUERY, 6'd0, 32'sd0, 32'sd0);
    send_item(KIND_QUERY, 6'd0, 32'sd5, 32'sd0);
    send_item(KIND_QUERY, 6'd0, 32'sd5, 32'sd1);
    send_item(KIND_QUERY, 6'd0, -32'sd1, 32'sd0);
    // row of the query passing through a vertex
    send_item(KIND_VERTEX, 6'd0, 32'sd0, 32'sd0);
    send_item(KIND_VERTEX, 6'd1, 32'sd20, 32'sd10);
    send_item(KIND_VERTEX, 6'd2, 32'sd0, 32'sd20);
    send_item(KIND_QUERY, 6'd0, 32'sd10, 32'sd10);
    send_item(KIND_QUERY, 6'd0, -32'sd10, 32'sd10);
    send_item(KIND_QUERY, 6'd0, 32'sd30, 32'sd10);
  endtask

  task automatic test_vertex_count_limits();
    logic [COUNT_BITS-1:0] counts [8];
    counts = '{7'd0, 7'd1, 7'd2, 7'd3, 7'd4, 7'd64, 7'd65, 7'd127};
    write_monotone(MAX_VERTS, 10, -32'sd200, 32'sd0);
    foreach (counts[c]) begin
      set_vertex_count(counts[c]);
      repeat (3) send_shaped_query(used_vertices(), 10);
    end
  endtask

  task automatic random_round();
    int                    pick;
    int                    n;
    int                    style;
    int                    s;
    coord_t                ox;
    coord_t                oy;
    logic [COUNT_BITS-1:0] cnt;
    pick = $urandom_range(0, 99);
    if (pick < 55) cnt = COUNT_BITS'($urandom_range(3, 8));
    else if (pick < 80) cnt = COUNT_BITS'($urandom_range(9, 63));
    else if (pick < 88) cnt = COUNT_BITS'(MAX_VERTS);
    else if (pick < 94) cnt = COUNT_BITS'($urandom_range(0, 2));
    else cnt = COUNT_BITS'($urandom_range(65, 127));
    if (cnt != count_reg || $urandom_range(0, 3) == 0) set_vertex_count(cnt);
    n     = used_vertices();
    style = $urandom_range(0, 3);
    s     = 1;
    ox    = coord_t'(int'($urandom_range(0, 2000000)) - 1000000);
    oy    = coord_t'(int'($urandom_range(0, 2000000)) - 1000000);
    if (style < 2) begin
      case ($urandom_range(0, 3))
        0: s = 1;
        1: s = 7;
        2: s = 1000;
        default: s = 100000;
      endcase
      write_monotone(n, s, ox, oy);
    end else begin
      for (int i = 0; i < n; i++) begin
        if (style == 2) begin
          send_item(KIND_VERTEX, INDEX_BITS'(i), ox + coord_t'(int'($urandom_range(0, 8)) - 4),
                    oy + coord_t'(int'($urandom_range(0, 8)) - 4));
        end else begin
          send_item(KIND_VERTEX, INDEX_BITS'(i), coord_t'($urandom), coord_t'($urandom));
        end
      end
    end
    if ($urandom_range(0, 4) == 0) begin
      send_item(KIND_VERTEX, INDEX_BITS'($urandom), coord_t'($urandom), coord_t'($urandom));
    end
    repeat ($urandom_range(2, 8)) begin
      send_shaped_query(n, s);
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        send_item(KIND_VERTEX, INDEX_BITS'($urandom_range(0, n - 1)),
                  poly_x[0] + coord_t'(s * (int'($urandom_range(0, 8)) - 4)),
                  poly_y[0] + coord_t'(s * (int'($urandom_range(0, 8)) - 4)));
      end else if (pick < 18) begin
        wait_all_answered();
      end
    end
  endtask

  task automatic test_random_polygons(input int target);
    while (items_sent < target) random_round();
  endtask

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.kind         = KIND_VERTEX;
    in_ch.vertex_index = '0;
    in_ch.coord_x      = '0;
    in_ch.coord_y      = '0;
    count_reg          = COUNT_RESET;
    send_gap           = 0;
    recv_gap           = 0;
    items_sent         = 0;
    queries_sent       = 0;
    relation_tally     = '{0, 0, 0};
    foreach (poly_x[i]) begin
      poly_x[i] = '0;
      poly_y[i] = '0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_gap = 32;
    recv_gap = 55;
    test_directed_shapes();
    test_vertex_count_limits();
    test_random_polygons(700);
    send_gap = 55;
    recv_gap = 32;
    test_random_polygons(1300);
    send_gap = 0;
    recv_gap = 0;
    test_random_polygons(ITEM_TARGET);

    wait_all_answered();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("%0d input transactions, %0d queries, %0d results checked", items_sent,
             queries_sent, results_seen);
    $display("expected outside %0d, boundary %0d, inside %0d; %0d errors", relation_tally[0],
             relation_tally[1], relation_tally[2], fail_count);
    if (fail_count == 0) begin
      $display("point_in_polygon_classifier: match");
    end else begin
      $display("point_in_polygon_classifier: mismatch");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/pip_pkg.sv
rtl/pip_in_if.sv
rtl/pip_out_if.sv
rtl/pip_vertex_cell.sv
rtl/pip_edge_eval.sv
rtl/point_in_polygon_classifier.sv
tb/point_in_polygon_classifier_test.sv
